[hdl/cla_pkg.sv]
// Shared constants and types for the CRLF line assembler.
// Used by cla_ram and crlf_line_assembler; depends on nothing else.
package cla_pkg;

  localparam int unsigned CLA_DEPTH = 64;
  localparam int unsigned CLA_BYTE_W = 8;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic [1:0] FUNC_RECEIVE = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_CLEAR   = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_LOAD,
    ST_SEND
  } cla_state_t;

endpackage

[hdl/crlf_line_assembler.sv]
// Top level of the CRLF line assembler: control sequencer, line state and result register.
// Depends on cla_pkg and on cla_ram for the line store.
//
// The block gathers received bytes into one text line held in a DEPTH-entry byte store.
// Each input word carries a command: receive appends rx_byte while no line is ready, and
// the line becomes ready once the last two stored bytes are CR then LF; if the store
// already holds DEPTH-1 bytes the byte is dropped and the line starts afresh. Bytes that
// arrive while a line is ready are ignored. A read hands out min(length, out_size-1) line
// bytes followed by a zero terminator word marked last, and then empties the line; with
// no line ready, or an out_size of zero, it returns a single status word (data 0, last 1,
// status 1) and leaves the line alone. Clear empties the line; the unused command code
// is ignored. The store has one registered read port, so each line byte of a read
// passes through a fetch from the store, a load into the output register and a
// hand-over, and the block takes no new input word until the last result word of
// a read has been taken.
// The store is not cleared after reset; only positions written since the last clear
// are ever read.
module crlf_line_assembler import cla_pkg::*; #(
  parameter int unsigned DEPTH = CLA_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_rx_byte,
  input  logic [15:0] in_out_size,
  // Result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_byte,
  output logic        out_last,
  output logic        out_status
);

  localparam int unsigned LW = $clog2(DEPTH);
  localparam logic [LW-1:0] LEN_FULL = LW'(DEPTH - 1);

  // Sequencer state and line bookkeeping.
  cla_state_t state_r, state_nxt;
  logic [LW-1:0] len_r, len_nxt;
  logic          line_ready_r, line_ready_nxt;
  // Set when the most recently stored byte was a carriage return.
  logic          prev_cr_r, prev_cr_nxt;
  // Read walk: current position and number of line bytes to hand out.
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;
  logic       out_status_r, out_status_nxt;

  // Line store port signals.
  logic          ram_we;
  logic          ram_re;
  logic [7:0]    ram_rdata;

  logic          in_take;
  logic          out_take;
  logic [15:0]   size_m1;
  logic [LW-1:0] read_cnt;

  cla_ram #(
    .WIDTH (CLA_BYTE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (len_r),
    .wdata (in_rx_byte),
    .re    (ram_re),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && (state_r == ST_IDLE);
  assign out_take  = out_valid_r && !out_stall;

  // Number of line bytes a read hands out: the line length, cut short to
  // leave room for the terminator in the reader's buffer.
  assign size_m1  = in_out_size - 16'd1;
  assign read_cnt = (size_m1 < {{(16 - LW){1'b0}}, len_r}) ? size_m1[LW-1:0] : len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      len_r        <= '0;
      line_ready_r <= 1'b0;
      prev_cr_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      len_r        <= len_nxt;
      line_ready_r <= line_ready_nxt;
      prev_cr_r    <= prev_cr_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    cnt_r        <= cnt_nxt;
    out_data_r   <= out_data_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    len_nxt        = len_r;
    line_ready_nxt = line_ready_r;
    prev_cr_nxt    = prev_cr_r;
    idx_nxt        = idx_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          unique case (in_func)
            FUNC_RECEIVE: begin
              if (!line_ready_r) begin
                if (len_r != LEN_FULL) begin
                  // Append the byte; CR then LF completes the line.
                  ram_we      = 1'b1;
                  len_nxt     = len_r + LW'(1);
                  prev_cr_nxt = (in_rx_byte == CH_CR);
                  if (prev_cr_r && (in_rx_byte == CH_LF)) begin
                    line_ready_nxt = 1'b1;
                  end
                end else begin
                  // Store full: drop the byte and start the line again.
                  len_nxt     = '0;
                  prev_cr_nxt = 1'b0;
                end
              end
            end
            FUNC_READ: begin
              if (!line_ready_r || (in_out_size == 16'd0)) begin
                out_valid_nxt  = 1'b1;
                out_data_nxt   = 8'd0;
                out_last_nxt   = 1'b1;
                out_status_nxt = 1'b1;
                state_nxt      = ST_SEND;
              end else begin
                idx_nxt   = '0;
                cnt_nxt   = read_cnt;
                state_nxt = ST_FETCH;
              end
            end
            FUNC_CLEAR: begin
              len_nxt        = '0;
              line_ready_nxt = 1'b0;
              prev_cr_nxt    = 1'b0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FETCH: begin
        if (idx_r != cnt_r) begin
          ram_re    = 1'b1;
          state_nxt = ST_LOAD;
        end else begin
          // All line bytes out: the terminator closes the read.
          out_valid_nxt  = 1'b1;
          out_data_nxt   = 8'd0;
          out_last_nxt   = 1'b1;
          out_status_nxt = 1'b0;
          state_nxt      = ST_SEND;
        end
      end
      ST_LOAD: begin
        out_valid_nxt  = 1'b1;
        out_data_nxt   = ram_rdata;
        out_last_nxt   = 1'b0;
        out_status_nxt = 1'b0;
        state_nxt      = ST_SEND;
      end
      ST_SEND: begin
        if (out_take) begin
          out_valid_nxt = 1'b0;
          if (out_last_r) begin
            // A delivered line is emptied; a status word leaves it alone.
            if (!out_status_r) begin
              len_nxt        = '0;
              line_ready_nxt = 1'b0;
              prev_cr_nxt    = 1'b0;
            end
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + LW'(1);
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_data_byte = out_data_r;
  assign out_last      = out_last_r;
  assign out_status    = out_status_r;

  // A result word is only ever offered from the hand-over state.
  a_valid_in_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_SEND))
    else $error("result word offered outside the hand-over state");

  // A ready line holds at least its CR and LF.
  a_ready_len: assert property (@(posedge clk) disable iff (!rst_n)
    line_ready_r |-> (len_r >= LW'(2)))
    else $error("line marked ready with fewer than two bytes");

  // A pending CR always sits inside a non-empty line.
  a_cr_len: assert property (@(posedge clk) disable iff (!rst_n)
    prev_cr_r |-> (len_r != '0))
    else $error("pending CR recorded on an empty line");

  // The read walk never passes its byte count.
  a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_FETCH) || (state_r == ST_LOAD)) |-> (idx_r <= cnt_r))
    else $error("read position beyond the byte count");

  // Handing over the terminator of a delivered line empties the line.
  a_clear_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && out_last_r && !out_status_r) |=> (!line_ready_r && (len_r == '0)))
    else $error("line not emptied after delivery");

endmodule

[hdl/cla_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Takes its default sizes from cla_pkg.
module cla_ram import cla_pkg::*; #(
  parameter int unsigned WIDTH = CLA_BYTE_W,
  parameter int unsigned DEPTH = CLA_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[sim/tb_crlf_line_assembler.sv]
// Self-checking testbench for crlf_line_assembler: directed and random command words
// against a built-in line predictor, with random gaps and stalls on both channels.
// Depends on cla_pkg and on the RTL of crlf_line_assembler and its line store.
module tb_crlf_line_assembler;
  timeunit 1ns;
  timeprecision 1ps;
  import cla_pkg::*;

  // The one command code that the package leaves unnamed; the block must ignore it.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int unsigned LINE_DEPTH = CLA_DEPTH;
  // Rough number of command words that the run aims for; it only ends the stimulus.
  localparam int unsigned WORD_TARGET = 420;

  // One word on the result channel.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       status;
  } line_result_t;

  // Clock, reset and every input of the block start at known values.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = FUNC_CLEAR;
  logic [7:0]  in_rx_byte = 8'h00;
  logic [15:0] in_out_size = 16'h0000;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_data_byte;
  logic        out_last;
  logic        out_status;

  // Predicted line state: the stored bytes, how many there are and whether the line
  // has been closed by CR then LF.
  logic [7:0]   line_bytes [LINE_DEPTH];
  int unsigned  pred_len = 0;
  bit           line_done = 1'b0;

  // Result words predicted but not yet seen, oldest first.
  line_result_t pending_results [$];

  int unsigned words_sent = 0;
  int unsigned mismatches = 0;
  bit          sender_idles = 1'b1;
  bit          receiver_idles = 1'b1;
  int unsigned stall_left = 0;

  crlf_line_assembler u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_rx_byte    (in_rx_byte),
    .in_out_size   (in_out_size),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_byte (out_data_byte),
    .out_last      (out_last),
    .out_status    (out_status)
  );

  always #10 clk = ~clk;

  // Timeout: far beyond the slowest correct run, even if every read were a full line
  // against the longest receiver stalls.
  initial begin
    #20_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Line predictor. It is called once for every command word that the block accepts and
  // queues the result words that the word must cause, in order.
  function automatic void predict_line_word(input logic [1:0] func, input logic [7:0] rx,
                                            input logic [15:0] size);
    int unsigned n;
    line_result_t r;
    case (func)
      FUNC_RECEIVE: begin
        // Bytes are ignored altogether once a line is waiting to be read.
        if (!line_done) begin
          if (pred_len < LINE_DEPTH - 1) begin
            line_bytes[pred_len] = rx;
            pred_len++;
            if (pred_len >= 2 && line_bytes[pred_len - 2] == CH_CR &&
                line_bytes[pred_len - 1] == CH_LF) begin
              line_done = 1'b1;
            end
          end else begin
            // The store is full: the byte is lost and the line starts again.
            pred_len = 0;
          end
        end
      end
      FUNC_READ: begin
        if (!line_done || size == 0) begin
          // A single status word, and the line is left as it is.
          r = '{data: 8'h00, last: 1'b1, status: 1'b1};
          pending_results.push_back(r);
        end else begin
          // The reader's buffer must keep room for the terminator, so a short buffer
          // truncates the line.
          n = pred_len;
          if (n >= size) begin
            n = size - 1;
          end
          for (int unsigned i = 0; i < n; i++) begin
            r = '{data: line_bytes[i], last: 1'b0, status: 1'b0};
            pending_results.push_back(r);
          end
          r = '{data: 8'h00, last: 1'b1, status: 1'b0};
          pending_results.push_back(r);
          pred_len = 0;
          line_done = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        pred_len = 0;
        line_done = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  // Sends one command word. Inputs change on the falling edge; the word counts as taken
  // at the first rising edge that sees valid high and stall low. A word that stays valid
  // for the next one is never lowered and raised in the same step.
  task automatic send_word(input logic [1:0] func, input logic [7:0] rx,
                           input logic [15:0] size);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 4) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_rx_byte  <= rx;
    in_out_size <= size;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // Words that the block merely ignores do not count towards the target.
    if (!(func == FUNC_UNUSED || (func == FUNC_RECEIVE && line_done))) begin
      words_sent++;
    end
    predict_line_word(func, rx, size);
  endtask

  task automatic send_byte(input logic [7:0] rx);
    send_word(FUNC_RECEIVE, rx, 16'($urandom));
  endtask

  task automatic read_line(input logic [15:0] size);
    send_word(FUNC_READ, 8'($urandom), size);
  endtask

  // Text of a line followed by the CR LF pair that closes it.
  task automatic send_line(input string body);
    for (int i = 0; i < body.len(); i++) begin
      send_byte(body[i]);
    end
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Random line content; a CR LF inside it simply closes the line early.
  task automatic send_random_line(input int unsigned len);
    for (int unsigned i = 0; i < len; i++) begin
      send_byte(8'($urandom));
    end
    send_byte(CH_CR);
    send_byte(CH_LF);
  endtask

  // Holds the command channel idle until every predicted result word has arrived, then
  // keeps waiting so that a receive or clear still in hand has finished.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Reads with no line ready, including a zero-sized buffer, the unused command code and a clear.
  task automatic test_no_line_reads();
    read_line(16'd16);
    read_line(16'd0);
    send_word(FUNC_UNUSED, 8'hA5, 16'hFFFF);
    send_word(FUNC_CLEAR, 8'h5A, 16'h0000);
    wait_for_drain();
  endtask

  // A line with the extreme byte values and a lone CR, a byte sent while it waits, a
  // zero-sized read that must leave it intact, then a read into the largest buffer.
  task automatic test_full_line_read();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(CH_CR);
    send_byte(8'h55);
    send_byte(CH_CR);
    send_byte(CH_LF);
    send_byte(8'h41);
    read_line(16'd0);
    read_line(16'hFFFF);
    wait_for_drain();
  endtask

  // Reader buffers too short for the line: room for the terminator only, and one short.
  task automatic test_short_reader_buffer();
    send_line("ab");
    read_line(16'd1);
    send_line("");
    read_line(16'd2);
    wait_for_drain();
  endtask

  // A clear part way through a line leaves nothing to read.
  task automatic test_clear_mid_line();
    send_byte("Z");
    send_word(FUNC_CLEAR, 8'($urandom), 16'($urandom));
    read_line(16'd3);
    wait_for_drain();
  endtask

  // Mostly whole lines with random content and random buffer sizes, mixed with store
  // overflows, broken line endings, drain pauses and words of any kind.
  task automatic test_random_traffic();
    int unsigned pick;
    int unsigned len;
    int unsigned sel;
    logic [7:0]  b;
    while (words_sent < WORD_TARGET) begin
      // Now and then change whether either side idles, so that long stretches without
      // any gaps or stalls occur as well.
      if ($urandom_range(0, 7) == 0) begin
        sender_idles   = $urandom_range(0, 1);
        receiver_idles = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        // Most lines are short; a few come close to filling the store.
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(40, 61) : $urandom_range(0, 12);
        send_random_line(len);
        if ($urandom_range(0, 4) == 0) begin
          send_byte(8'($urandom));
        end
        sel = $urandom_range(0, 19);
        if (sel == 0) begin
          read_line(16'd0);
          read_line(16'($urandom));
        end else if (sel < 6) begin
          read_line(16'($urandom_range(1, len + 2)));
        end else if (sel < 8) begin
          send_word(FUNC_CLEAR, 8'($urandom), 16'($urandom));
        end else begin
          read_line(16'($urandom_range(len + 3, 65535)));
        end
      end else if (pick < 73) begin
        // Fill the store without ever closing the line, so that a byte is dropped.
        len = $urandom_range(64, 66);
        for (int unsigned i = 0; i < len; i++) begin
          b = 8'($urandom);
          if (b == CH_CR) begin
            b = 8'h0C;
          end
          send_byte(b);
        end
      end else if (pick < 78) begin
        wait_for_drain();
      end else if (pick < 85) begin
        // CR followed by something other than LF does not end a line.
        send_byte(CH_CR);
        b = 8'($urandom);
        if (b == CH_LF) begin
          b = 8'h0B;
        end
        send_byte(b);
        read_line(16'($urandom));
      end else begin
        send_word(2'($urandom), 8'($urandom), 16'($urandom));
      end
    end
  endtask

  // Receiver: after each result word it takes, it draws how many cycles to stall next.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: every word taken is compared field by field with the oldest
  // prediction; a word with no prediction waiting is a failure too.
  always @(posedge clk) begin
    line_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result word with none expected: expected nothing, actual %h/%b/%b",
                 $time, out_data_byte, out_last, out_status);
      end else begin
        want = pending_results.pop_front();
        if (out_data_byte !== want.data) begin
          mismatches++;
          $display("%0t: data_byte mismatch: expected %h, actual %h",
                   $time, want.data, out_data_byte);
        end
        if (out_last !== want.last) begin
          mismatches++;
          $display("%0t: last mismatch: expected %b, actual %b",
                   $time, want.last, out_last);
        end
        if (out_status !== want.status) begin
          mismatches++;
          $display("%0t: status mismatch: expected %b, actual %b",
                   $time, want.status, out_status);
        end
      end
      stall_left = receiver_idles ? $urandom_range(0, 4) : 0;
    end
  end

  initial begin
    // Synchronous reset held from the start of the run, then released on a falling edge.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_no_line_reads();
    test_full_line_read();
    test_short_reader_buffer();
    test_clear_mid_line();
    test_random_traffic();
    wait_for_drain();

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
